// ===== sv/mse_pkg.sv =====
// Package for the Morse symbol encoder: symbol codes, character classes,
// the descriptor passed between the front and back parts, and code tables.
// It has no dependencies.
package mse_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int MAX_SYMS    = 6;
    localparam int CODE_LEN    = 5;

    typedef enum logic [1:0] {
        SYM_DASH       = 2'd0,
        SYM_DOT        = 2'd1,
        SYM_LETTER_GAP = 2'd2,
        SYM_WORD_GAP   = 2'd3
    } sym_t;

    typedef enum logic [1:0] {
        CLS_SPACE = 2'd0,
        CLS_CODE  = 2'd1,
        CLS_BAD   = 2'd2
    } cls_t;

    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // One accepted character, ready to be played out symbol by symbol.
    typedef struct packed {
        logic [MAX_SYMS-1:0][1:0] syms;
        logic [2:0]               cnt;
        logic                     bad;
        logic                     eom;
    } desc_t;

    // Codes are left-justified: the first symbol is the top bit, 1 is a dot.
    localparam logic [4:0] LETTER_CODE [26] = '{
        5'b10000, 5'b01110, 5'b01010, 5'b01100, 5'b10000, 5'b11010,
        5'b00100, 5'b11110, 5'b11000, 5'b10000, 5'b01000, 5'b10110,
        5'b00000, 5'b01000, 5'b00000, 5'b10010, 5'b00100, 5'b10100,
        5'b11100, 5'b00000, 5'b11000, 5'b11100, 5'b10000, 5'b01100,
        5'b01000, 5'b00110
    };

    localparam logic [2:0] LETTER_LEN [26] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
        3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
        3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
    };

    localparam logic [4:0] DIGIT_CODE [10] = '{
        5'b00000, 5'b10000, 5'b11000, 5'b11100, 5'b11110,
        5'b11111, 5'b01111, 5'b00111, 5'b00011, 5'b00001
    };

    function automatic cls_t classify(input logic [7:0] ch);
        cls_t c;
        c = CLS_BAD;
        if (ch == CHAR_SPACE)
        begin
            c = CLS_SPACE;
        end
        else if ((ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A)
                 || (ch >= 8'h30 && ch <= 8'h39))
        begin
            c = CLS_CODE;
        end
        return c;
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return (ch[7:4] == 4'h3);
    endfunction

    function automatic logic [4:0] code_bits(input logic [7:0] ch);
        logic [4:0] idx;
        idx = ch[4:0] - 5'd1;
        if (is_digit(ch))
        begin
            return DIGIT_CODE[ch[3:0]];
        end
        return LETTER_CODE[idx];
    endfunction

    function automatic logic [2:0] code_len(input logic [7:0] ch);
        logic [4:0] idx;
        idx = ch[4:0] - 5'd1;
        if (is_digit(ch))
        begin
            return 3'(CODE_LEN);
        end
        return LETTER_LEN[idx];
    endfunction

endpackage

// ===== sv/mse_if.sv =====
// Valid/ready channel interfaces for characters in and symbols out.
// Depends on nothing.
interface mse_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       end_of_message;

    modport source (output valid, output character, output end_of_message, input ready);
    modport sink (input valid, input character, input end_of_message, output ready);
endinterface

interface mse_sym_if;
    logic       valid;
    logic       ready;
    logic [1:0] symbol;
    logic       bad_character;
    logic       last_of_item;
    logic       message_done;

    modport source (output valid, output symbol, output bad_character,
                    output last_of_item, output message_done, input ready);
    modport sink (input valid, input symbol, input bad_character,
                  input last_of_item, input message_done, output ready);
endinterface

// ===== sv/mse_front.sv =====
// Front part: classifies each character and builds its symbol descriptor.
// Depends on mse_pkg and mse_char_if.
module mse_front
(
    input  logic            clk,
    input  logic            rst_n,
    mse_char_if.sink        chars,
    output logic            push_valid,
    input  logic            push_ready,
    output mse_pkg::desc_t  push_data
);

    logic                 prev_letter_reg;
    logic                 prev_letter_next;
    mse_pkg::cls_t        cls;
    logic [4:0]           bits;
    logic [2:0]           len;
    logic [4:0][1:0]      code_syms;
    logic                 accept;

    assign cls         = mse_pkg::classify(chars.character);
    assign bits        = mse_pkg::code_bits(chars.character);
    assign len         = mse_pkg::code_len(chars.character);
    assign chars.ready = push_ready;
    assign push_valid  = chars.valid;
    assign accept      = chars.valid && push_ready;

    always_comb
    begin
        for (int i = 0; i < mse_pkg::CODE_LEN; i++)
        begin
            code_syms[i] = bits[mse_pkg::CODE_LEN-1-i] ? mse_pkg::SYM_DOT : mse_pkg::SYM_DASH;
        end
    end

    always_comb
    begin
        push_data.eom  = chars.end_of_message;
        push_data.bad  = 1'b0;
        push_data.cnt  = 3'd1;
        push_data.syms = '0;
        case (cls)
            mse_pkg::CLS_SPACE:
            begin
                push_data.syms[0] = mse_pkg::SYM_WORD_GAP;
            end
            mse_pkg::CLS_CODE:
            begin
                if (prev_letter_reg)
                begin
                    push_data.syms = {code_syms, mse_pkg::SYM_LETTER_GAP};
                    push_data.cnt  = len + 3'd1;
                end
                else
                begin
                    push_data.syms = {2'b00, code_syms};
                    push_data.cnt  = len;
                end
            end
            default:
            begin
                push_data.syms[0] = mse_pkg::SYM_DASH;
                push_data.bad     = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        prev_letter_next = prev_letter_reg;
        if (accept)
        begin
            prev_letter_next = (cls == mse_pkg::CLS_CODE) && !chars.end_of_message;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_letter_reg <= 1'b0;
        end
        else
        begin
            prev_letter_reg <= prev_letter_next;
        end
    end

endmodule

// ===== sv/mse_queue.sv =====
// Short descriptor queue between the front and back parts.
// Depends on mse_pkg.
module mse_queue
#(
    parameter int DEPTH = mse_pkg::QUEUE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  mse_pkg::desc_t  push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output mse_pkg::desc_t  pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mse_pkg::desc_t     entries_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entries_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue occupancy exceeds its depth");

    a_full_no_growth: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == CNT_W'(DEPTH)) |=> (count_reg <= CNT_W'(DEPTH)) && $past(!push))
        else $error("transaction pushed into a full queue");

    a_empty_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push && count_reg == CNT_W'(1)) |=> !pop_valid)
        else $error("queue not empty after its last entry left");

endmodule

// ===== sv/mse_back.sv =====
// Back part: plays a descriptor out as one symbol transaction per cycle while the output is ready.
// Depends on mse_pkg and mse_sym_if.
module mse_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  mse_pkg::desc_t  pop_data,
    mse_sym_if.source       symbols
);

    logic                                 cur_valid_reg;
    logic                                 cur_valid_next;
    logic [mse_pkg::MAX_SYMS-1:0][1:0]    syms_reg;
    logic [mse_pkg::MAX_SYMS-1:0][1:0]    syms_next;
    logic [2:0]                           cnt_reg;
    logic [2:0]                           cnt_next;
    logic                                 bad_reg;
    logic                                 bad_next;
    logic                                 eom_reg;
    logic                                 eom_next;
    logic                                 last;
    logic                                 sent;

    assign last                  = (cnt_reg == 3'd1);
    assign sent                  = symbols.valid && symbols.ready;
    assign pop_ready             = !cur_valid_reg || (sent && last);
    assign symbols.valid         = cur_valid_reg;
    assign symbols.symbol        = syms_reg[0];
    assign symbols.bad_character = bad_reg;
    assign symbols.last_of_item  = last;
    assign symbols.message_done  = last && eom_reg;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        syms_next      = syms_reg;
        cnt_next       = cnt_reg;
        bad_next       = bad_reg;
        eom_next       = eom_reg;
        if (pop_ready)
        begin
            cur_valid_next = pop_valid;
            syms_next      = pop_data.syms;
            cnt_next       = pop_data.cnt;
            bad_next       = pop_data.bad;
            eom_next       = pop_data.eom;
        end
        else if (sent)
        begin
            syms_next = {2'b00, syms_reg[mse_pkg::MAX_SYMS-1:1]};
            cnt_next  = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        syms_reg <= syms_next;
        bad_reg  <= bad_next;
        eom_reg  <= eom_next;
    end

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (cnt_reg != 3'd0 && cnt_reg <= 3'(mse_pkg::MAX_SYMS)))
        else $error("active descriptor has no symbols left");

    a_mid_item_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (sent && !last) |=> symbols.valid && cnt_reg == $past(cnt_reg) - 3'd1)
        else $error("symbol transaction lost inside a character");

    a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
        (symbols.valid && symbols.bad_character)
            |-> (last && symbols.symbol == mse_pkg::SYM_DASH))
        else $error("bad character result is not a single dash result");

endmodule

// ===== sv/morse_symbol_encoder.sv =====
// Morse symbol encoder: an accepted character is registered in the descriptor queue and then in
// the back part's output register before its first symbol. It gives one symbol transaction per
// cycle while the output is ready, one to six in all; the back part is the limit.
// Reset clears the letter-gap memory, the descriptor queue and the output valid and count.
// Depends on mse_pkg, mse_if, mse_front, mse_queue and mse_back.
module morse_symbol_encoder
#(
    parameter int QUEUE_DEPTH = mse_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    mse_char_if.sink    chars,
    mse_sym_if.source   symbols
);

    logic            push_valid;
    logic            push_ready;
    mse_pkg::desc_t  push_data;
    logic            pop_valid;
    logic            pop_ready;
    mse_pkg::desc_t  pop_data;

    mse_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    mse_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    mse_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .symbols   (symbols)
    );

endmodule
